FILE: design/aes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 package
// S-box, round constants, round functions and shared types.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned BlockW    = 128;
  localparam int unsigned HalfW     = 64;
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [CfgIdxW-1:0] CfgKeyHigh = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgKeyLow  = 1'b1;

  typedef logic [BlockW-1:0] block_t;

  typedef struct packed {
    logic   start;
    block_t key;
  } key_ctrl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // Byte i of a block sits in bits 127-8i downto 120-8i.
  function automatic logic [7:0] get_byte(block_t s, int unsigned i);
    get_byte = s[BlockW-1-8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic block_t sub_shift(block_t s);
    block_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BlockW-1-8*(4*c+r) -: 8] = SBOX[get_byte(s, 4*((c+r)%4)+r)];
      end
    end
    sub_shift = t;
  endfunction

  function automatic block_t mix_columns(block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0  = get_byte(s, 4*c);
      a1  = get_byte(s, 4*c+1);
      a2  = get_byte(s, 4*c+2);
      a3  = get_byte(s, 4*c+3);
      all = a0 ^ a1 ^ a2 ^ a3;
      t[BlockW-1-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[BlockW-1-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[BlockW-1-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[BlockW-1-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    mix_columns = t;
  endfunction

  function automatic block_t next_round_key(block_t k, logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t  = {SBOX[w3[23:16]], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    t  = t ^ {rc, 24'h0};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_round_key = {w0, w1, w2, w3};
  endfunction

endpackage
`default_nettype wire

FILE: design/aes_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES block stream interface
// Valid/ready channel carrying one 128-bit block as two 64-bit halves.
// ----------------------------------------------------------------------------
interface aes_stream_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_high;
  logic [63:0] data_low;

  modport source (output valid, output data_high, output data_low, input ready);
  modport sink   (input valid, input data_high, input data_low, output ready);
endinterface
`default_nettype wire

FILE: design/aes_key_expand.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES key expander
// Computes one round key per cycle and keeps all eleven in registers.
// ----------------------------------------------------------------------------
module aes_key_expand (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire aes_pkg::key_ctrl_t    ctrl_i,
  output      logic                  busy_o,
  output      aes_pkg::block_t       rk_o [aes_pkg::NumRounds+1]
);

  aes_pkg::block_t rk_q [aes_pkg::NumRounds+1];
  logic [3:0]      step_q;
  logic            busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      for (int i = 0; i <= aes_pkg::NumRounds; i++) rk_q[i] <= '0;
    end else if (ctrl_i.start) begin
      rk_q[0] <= ctrl_i.key;
      busy_q  <= 1'b1;
      step_q  <= 4'd1;
    end else if (busy_q) begin
      rk_q[step_q] <= aes_pkg::next_round_key(rk_q[step_q - 4'd1],
                                              aes_pkg::RCON[step_q - 4'd1]);
      if (step_q == 4'(aes_pkg::NumRounds)) begin
        busy_q <= 1'b0;
      end
      step_q <= step_q + 4'd1;
    end
  end

  assign busy_o = busy_q;
  assign rk_o   = rk_q;

endmodule
`default_nettype wire

FILE: design/aes_round_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES round stage
// One registered cipher round with its own valid bit and stall control.
// ----------------------------------------------------------------------------
module aes_round_stage #(
  parameter bit FinalRound = 1'b0
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output      logic            ready_o,
  input  wire aes_pkg::block_t state_i,
  input  wire aes_pkg::block_t rk_i,
  output      logic            valid_o,
  input  wire logic            ready_i,
  output      aes_pkg::block_t state_o
);

  logic            valid_q;
  aes_pkg::block_t state_q, state_d;

  always_comb begin
    state_d = aes_pkg::sub_shift(state_i);
    if (!FinalRound) begin
      state_d = aes_pkg::mix_columns(state_d);
    end
    state_d = state_d ^ rk_i;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      state_q <= state_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

endmodule
`default_nettype wire

FILE: design/aes128_block_encrypt_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 block encryptor
// Unrolled ten-round pipeline: one 128-bit block per cycle when not stalled.
// ----------------------------------------------------------------------------
// Plaintext items enter on in_if and ciphertext items leave on out_if, both
// valid/ready channels with the block split into a high and a low half,
// byte 0 in the top bits of the high half.
// The key is written through cfg_we_i/cfg_idx_i/cfg_data_i, index 0 for the
// high half and index 1 for the low half. Each write restarts the key
// expander: round key zero is loaded at the write edge and the other ten
// follow one per cycle. The input is held off in the write cycle and while
// the expander is busy.
// The datapath has eleven register stages: the initial key XOR and ten
// rounds, one round per stage. Throughput is one item per cycle while the
// input is not held off and the receiver does not stall.
// Reset clears all valid bits, the key registers and the round keys.
// When the receiver stalls, each full stage holds its item; the stall passes
// back combinationally to the first empty stage; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [aes_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [aes_pkg::HalfW-1:0]   cfg_data_i,
  aes_stream_if.sink                       in_if,
  aes_stream_if.source                     out_if
);

  localparam int unsigned N = aes_pkg::NumRounds;

  logic [63:0]        key_high_q, key_low_q;
  aes_pkg::key_ctrl_t kctrl;
  aes_pkg::block_t    rk [N+1];
  logic               key_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        aes_pkg::CfgKeyHigh: key_high_q <= cfg_data_i;
        aes_pkg::CfgKeyLow:  key_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    kctrl.start = cfg_we_i;
    kctrl.key   = {key_high_q, key_low_q};
    unique case (cfg_idx_i)
      aes_pkg::CfgKeyHigh: kctrl.key = {cfg_data_i, key_low_q};
      aes_pkg::CfgKeyLow:  kctrl.key = {key_high_q, cfg_data_i};
      default: ;
    endcase
  end

  aes_key_expand u_key (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (kctrl),
    .busy_o (key_busy),
    .rk_o   (rk)
  );

  // Stage 0: initial key XOR.
  logic            v0_q;
  aes_pkg::block_t s0_q;
  logic            adv0;
  logic            rdy [N+1];
  logic            vld [N+1];
  aes_pkg::block_t st  [N+1];

  assign adv0        = !v0_q || rdy[0];
  assign in_if.ready = adv0 && !key_busy && !cfg_we_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv0) begin
      v0_q <= in_if.valid && in_if.ready;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      s0_q <= {in_if.data_high, in_if.data_low} ^ rk[0];
    end
  end

  assign vld[0] = v0_q;
  assign st[0]  = s0_q;

  for (genvar r = 1; r <= N; r++) begin : g_round
    aes_round_stage #(
      .FinalRound (r == N)
    ) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[r-1]),
      .ready_o (rdy[r-1]),
      .state_i (st[r-1]),
      .rk_i    (rk[r]),
      .valid_o (vld[r]),
      .ready_i (rdy[r]),
      .state_o (st[r])
    );
  end

  assign rdy[N]           = out_if.ready;
  assign out_if.valid     = vld[N];
  assign out_if.data_high = st[N][127:64];
  assign out_if.data_low  = st[N][63:0];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> out_if.valid)
    else $error("Output item dropped during stall.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld[N-1] && !rdy[N-1]) |-> (vld[N] && !out_if.ready))
    else $error("Last round stalled without downstream backpressure.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v0_q && !rdy[0]) |=> v0_q && $stable(s0_q))
    else $error("First stage lost its item while stalled.");

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block encryptor testbench
// Writes keys between phases, streams plaintext items under random idling
// on both sides and checks every ciphertext item against a local AES model.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned ExpandWait    = 16;
  localparam int unsigned DrainWait     = 20;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [aes_pkg::CfgIdxW-1:0] cfg_idx_i = aes_pkg::CfgKeyHigh;
  logic [aes_pkg::HalfW-1:0] cfg_data_i = '0;

  aes_stream_if plain_if ();
  aes_stream_if cipher_if ();

  aes128_block_encrypt_top dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if     (plain_if),
    .out_if    (cipher_if)
  );

  always #1 clk_i = ~clk_i;

  aes_pkg::block_t round_keys [11];
  logic [aes_pkg::HalfW-1:0] key_high_q = '0;
  logic [aes_pkg::HalfW-1:0] key_low_q = '0;
  aes_pkg::block_t plain_queue [$];
  aes_pkg::block_t cipher_queue [$];
  bit no_idle = 1'b0;
  int unsigned errors = 0;
  int unsigned blocks_in = 0;
  int unsigned blocks_out = 0;
  int unsigned key_writes = 0;
  int unsigned quiet_cycles = 0;

  function automatic logic [7:0] gf_double(logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic void expand_round_keys();
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0] rc;
    w[0] = key_high_q[63:32];
    w[1] = key_high_q[31:0];
    w[2] = key_low_q[63:32];
    w[3] = key_low_q[31:0];
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {aes_pkg::SBOX[t[23:16]], aes_pkg::SBOX[t[15:8]], aes_pkg::SBOX[t[7:0]],
             aes_pkg::SBOX[t[31:24]]} ^ {rc, 24'h0};
        rc = gf_double(rc);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) begin
      round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    end
  endfunction

  function automatic aes_pkg::block_t cipher_of(aes_pkg::block_t plain);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    aes_pkg::block_t b;
    b = plain ^ round_keys[0];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int i = 0; i < 16; i++) s[i] = b[127-8*i -: 8];
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) t[4*c+r] = aes_pkg::SBOX[s[4*((c+r)%4)+r]];
      end
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ all ^ gf_double(a0 ^ a1);
          t[4*c+1] = a1 ^ all ^ gf_double(a1 ^ a2);
          t[4*c+2] = a2 ^ all ^ gf_double(a2 ^ a3);
          t[4*c+3] = a3 ^ all ^ gf_double(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) b[127-8*i -: 8] = t[i];
      b = b ^ round_keys[rnd];
    end
    return b;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("ERROR item %0d %s: got %h expected %h", blocks_out, what, got, want);
  endtask

  task automatic write_key(logic [aes_pkg::CfgIdxW-1:0] idx,
                           logic [aes_pkg::HalfW-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    if (idx == aes_pkg::CfgKeyHigh) key_high_q = value;
    else key_low_q = value;
    expand_round_keys();
    key_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    repeat (ExpandWait) @(posedge clk_i);
  endtask

  task automatic drain();
    while (plain_queue.size() != 0 || plain_if.valid || cipher_queue.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainWait) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_half();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'h1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Sender: holds an item until it is taken, then may idle before the next.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plain_if.valid <= 1'b0;
      plain_if.data_high <= '0;
      plain_if.data_low <= '0;
    end else begin
      if (plain_if.valid && plain_if.ready) begin
        cipher_queue.push_back(cipher_of({plain_if.data_high, plain_if.data_low}));
        blocks_in++;
      end
      if (!plain_if.valid || plain_if.ready) begin
        if (plain_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= 28)) begin
          aes_pkg::block_t nxt;
          nxt = plain_queue.pop_front();
          plain_if.valid <= 1'b1;
          plain_if.data_high <= nxt[127:64];
          plain_if.data_low <= nxt[63:0];
        end else begin
          plain_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, checks each ciphertext item in order.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cipher_if.ready <= 1'b0;
    end else begin
      if (cipher_if.valid && cipher_if.ready) begin
        if (cipher_queue.size() == 0) begin
          report("unexpected high", cipher_if.data_high, '0);
        end else begin
          aes_pkg::block_t want;
          want = cipher_queue.pop_front();
          if (cipher_if.data_high !== want[127:64])
            report("cipher_high", cipher_if.data_high, want[127:64]);
          if (cipher_if.data_low !== want[63:0])
            report("cipher_low", cipher_if.data_low, want[63:0]);
        end
        blocks_out++;
      end
      cipher_if.ready <= no_idle || $urandom_range(0, 99) >= 28;
    end
  end

  always @(posedge clk_i) begin
    if ((plain_if.valid && plain_if.ready) || (cipher_if.valid && cipher_if.ready) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Timeout with %0d items outstanding.", cipher_queue.size());
      $display("aes128_block_encrypt_top: mismatch");
      $finish;
    end
  end

  initial begin
    for (int r = 0; r < 11; r++) round_keys[r] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Before any key write every round key is zero.
    plain_queue.push_back('0);
    plain_queue.push_back('1);
    plain_queue.push_back(128'h00112233445566778899aabbccddeeff);
    drain();

    write_key(aes_pkg::CfgKeyHigh, 64'h0001020304050607);
    write_key(aes_pkg::CfgKeyLow, 64'h08090a0b0c0d0e0f);
    plain_queue.push_back(128'h00112233445566778899aabbccddeeff);
    plain_queue.push_back('0);
    plain_queue.push_back('1);
    plain_queue.push_back(128'h8000000000000000_0000000000000001);
    drain();

    write_key(aes_pkg::CfgKeyHigh, '1);
    write_key(aes_pkg::CfgKeyLow, '1);
    plain_queue.push_back('0);
    plain_queue.push_back('1);
    plain_queue.push_back(128'hffffffffffffffff_0000000000000000);
    drain();

    // Only one half rewritten; the other keeps its value.
    write_key(aes_pkg::CfgKeyLow, '0);
    plain_queue.push_back('1);
    plain_queue.push_back(128'h0123456789abcdef_fedcba9876543210);
    drain();

    write_key(aes_pkg::CfgKeyHigh, '0);
    plain_queue.push_back('0);
    plain_queue.push_back('1);
    drain();

    for (int ph = 0; ph < 11; ph++) begin
      no_idle = (ph == 5);
      case ($urandom_range(0, 2))
        0: write_key(aes_pkg::CfgKeyHigh, rand_half());
        1: write_key(aes_pkg::CfgKeyLow, rand_half());
        default: begin
          write_key(aes_pkg::CfgKeyHigh, rand_half());
          write_key(aes_pkg::CfgKeyLow, rand_half());
        end
      endcase
      for (int n = 0; n < 72; n++) plain_queue.push_back({rand_half(), rand_half()});
      drain();
    end
    no_idle = 1'b0;

    $display("Encrypted %0d items under %0d key writes, including zero round keys,",
             blocks_out, key_writes);
    $display("single-half key updates and a stretch without any idling.");
    if (errors == 0) begin
      $display("aes128_block_encrypt_top: match");
    end else begin
      $display("aes128_block_encrypt_top: mismatch");
    end
    $finish;
  end

endmodule
